FILE: src/hpcc_pkg.sv
// Shared constants, types and command structs of the hydraulic pressure cycle controller.
`timescale 1ns / 1ps
`default_nettype none
package hpcc_pkg;

    // Field widths.
    localparam int unsigned KEY_W     = 2;
    localparam int unsigned P_W       = 12;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned SPAN_W    = 20;
    localparam int unsigned TORQ_W    = 17;
    localparam int unsigned ORT_W     = 8;
    localparam int unsigned STATE2_W  = 2;
    localparam int unsigned WAIT_W    = 16;
    localparam int unsigned IDLE_W    = 12;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 20;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 40;

    // Target divider: dividend is torque * 160000, quotient kept to Q_W bits and saturated.
    localparam int unsigned TGT_SCALE = 160000;
    localparam int unsigned PROD_W    = 35;
    localparam int unsigned Q_W       = 13;
    localparam int unsigned HI_W      = PROD_W - Q_W;
    localparam int unsigned STEP_W    = 4;
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(Q_W);

    // Pressure constants in 1/16 units.
    localparam logic [Q_W-1:0] CAP_P      = Q_W'(1120);
    localparam logic [Q_W-1:0] BOLT_LIM   = Q_W'(320);
    localparam logic [Q_W-1:0] BOLT_OFS   = Q_W'(32);
    localparam logic [P_W-1:0] RET_LO     = P_W'(96);
    localparam logic [P_W-1:0] RET_HI     = P_W'(160);
    localparam logic [P_W-1:0] MAN_LIM    = P_W'(320);
    localparam logic [P_W-1:0] MAN_OFS_LO = P_W'(72);
    localparam logic [P_W-1:0] MAN_OFS_HI = P_W'(48);
    localparam logic [P_W-1:0] P_MAX      = '1;

    // Window and report scaling: latch is floor(p*24/25) by reciprocal multiply.
    localparam int unsigned CMP_W     = 20;
    localparam int unsigned X_W       = 17;
    localparam int unsigned RECIP_W   = 18;
    localparam int unsigned CAND_W    = X_W + RECIP_W;
    localparam int unsigned RECIP     = 167773;
    localparam int unsigned RECIP_SH  = 22;

    localparam logic [IDLE_W-1:0] IDLE_LIMIT = IDLE_W'(1500);
    localparam logic [IDLE_W-1:0] IDLE_HOLD  = IDLE_W'(4000);
    localparam int unsigned       WAIT_SCALE = 200;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPANNER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOLT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORT     = 3'd5;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_TORQUE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BOLT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GEAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SENSOR = 3'd5;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_NONE   = 2'd0;
    localparam logic [KEY_W-1:0] KEY_MANUAL = 2'd1;
    localparam logic [KEY_W-1:0] KEY_AUTO   = 2'd2;
    localparam logic [KEY_W-1:0] KEY_STOP   = 2'd3;

    // Valve mode codes.
    localparam logic [1:0] VM_NONE   = 2'd0;
    localparam logic [1:0] VM_AUTO   = 2'd1;
    localparam logic [1:0] VM_MANUAL = 2'd2;

    // Run state codes.
    localparam logic [STATE2_W-1:0] RUN_ACTIVE  = 2'd0;
    localparam logic [STATE2_W-1:0] RUN_STOPPED = 2'd1;
    localparam logic [STATE2_W-1:0] RUN_ENDED   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_INIT   = 5'b00010,
        S_DIV    = 5'b00100,
        S_EVAL   = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic capture;
        logic div_init;
        logic div_step;
        logic eval;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_sat;
    } t_status;

endpackage
`default_nettype wire

FILE: src/hydraulic_pressure_cycle_controller.sv
// Top level of the hydraulic pressure cycle controller: sequencer plus datapath.
//
// Usage. Each input word on the s_axis channel is one control tick: a key code
// and a pressure sample. For every accepted word the block returns exactly one
// result word on the m_axis channel with the motor, valve and lamp drives, the
// cycle state, the reported pressure and the oil return wait.
// The six setup registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data while no tick is in flight; a write takes effect at that edge.
// A tick passes through the divider set-up, the 13-step serial divider that turns
// the selected torque and the spanner coefficient into the target pressure (cut
// short when the target saturates), the evaluation and the commit of the result.
// One word is processed at a time: the next word is not taken until the result
// of the last one has been committed.
// s_axis_tready is high only while the block waits for a new word; it may take
// the next word while the previous result still sits in the output register.
// If the receiver stalls, the result is held stable on m_axis_tdata and the
// next tick finishes its computation and then waits before updating the tick state.
// Reset (synchronous, active low) returns all control state and the setup
// registers to their defaults; the spanner coefficient resets to 1.
`timescale 1ns / 1ps
`default_nettype none
module hydraulic_pressure_cycle_controller (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [hpcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [hpcc_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: key_code[1:0], pressure_sample[13:2], zero pad [15:14].
    input  wire  [hpcc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // Fields from bit 0: motor_on[0], valves_open[1], warning_led[2], start_led[3],
    // cycle_state[5:4], auto_drive[6], pressure_reached[7], reported_pressure[19:8],
    // reopen_wait[35:20], zero pad [39:36].
    output logic [hpcc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    hpcc_pkg::t_cmd    w_cmd;
    hpcc_pkg::t_status w_status;

    // Sequencer: owns the handshakes and steps the datapath through a tick.
    hpcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: setup registers, target divider, tick state and the output word.
    hpcc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_key_code        (s_axis_tdata[hpcc_pkg::KEY_W-1:0]),
        .i_pressure_sample (s_axis_tdata[hpcc_pkg::KEY_W +: hpcc_pkg::P_W]),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_tdata           (m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: src/hpcc_ctrl.sv
// Sequencer of the hydraulic pressure cycle controller: handshakes and datapath commands.
`timescale 1ns / 1ps
`default_nettype none
module hpcc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    input  hpcc_pkg::t_status    i_status,
    output hpcc_pkg::t_cmd       o_cmd
);

    hpcc_pkg::t_state                   r_state, n_state;
    logic [hpcc_pkg::STEP_W-1:0]        r_step, n_step;
    logic                               r_out_valid, n_out_valid;
    logic                               w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == hpcc_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        unique case (r_state)
            hpcc_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = hpcc_pkg::S_INIT;
                end
            end
            hpcc_pkg::S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = hpcc_pkg::S_DIV;
            end
            hpcc_pkg::S_DIV: begin
                // A saturated quotient needs no further steps.
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (i_status.div_sat || (r_step == hpcc_pkg::DIV_STEPS - 1'b1)) begin
                    n_state = hpcc_pkg::S_EVAL;
                end
            end
            hpcc_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = hpcc_pkg::S_COMMIT;
            end
            hpcc_pkg::S_COMMIT: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = hpcc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hpcc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpcc_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: src/hpcc_target.sv
// Target pressure unit: torque scaling multiply and a serial divider by the spanner coefficient.
`timescale 1ns / 1ps
`default_nettype none
module hpcc_target (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  hpcc_pkg::t_cmd                    i_cmd,
    input  wire  [hpcc_pkg::TORQ_W-1:0]       i_torque,
    input  wire  [hpcc_pkg::SPAN_W-1:0]       i_spanner,
    output hpcc_pkg::t_status                 o_status,
    output logic [hpcc_pkg::Q_W-1:0]          o_quot
);

    logic [hpcc_pkg::PROD_W-1:0] r_prod;
    logic [hpcc_pkg::SPAN_W-1:0] r_rem;
    logic [hpcc_pkg::Q_W-1:0]    r_low;
    logic [hpcc_pkg::Q_W-1:0]    r_quot;
    logic                        r_sat;
    logic [hpcc_pkg::SPAN_W:0]   w_rem2;
    logic                        w_ge;
    logic [hpcc_pkg::SPAN_W:0]   w_diff;

    assign w_rem2 = {r_rem, r_low[hpcc_pkg::Q_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, i_spanner});
    assign w_diff = w_rem2 - {1'b0, i_spanner};

    // A zero coefficient also marks saturation; the caller replaces it with the cap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.div_init) begin
            r_sat <= (i_spanner == '0) ||
                     (r_prod[hpcc_pkg::PROD_W-1:hpcc_pkg::Q_W] >=
                      hpcc_pkg::HI_W'(i_spanner));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prod <= hpcc_pkg::PROD_W'(i_torque) *
                      hpcc_pkg::PROD_W'(hpcc_pkg::TGT_SCALE);
        end
        if (i_cmd.div_init) begin
            // The upper part is below the divisor unless saturated, so it fits.
            r_rem  <= r_prod[hpcc_pkg::Q_W +: hpcc_pkg::SPAN_W];
            r_low  <= r_prod[hpcc_pkg::Q_W-1:0];
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[hpcc_pkg::SPAN_W-1:0] : w_rem2[hpcc_pkg::SPAN_W-1:0];
            r_low  <= {r_low[hpcc_pkg::Q_W-2:0], 1'b0};
            r_quot <= {r_quot[hpcc_pkg::Q_W-2:0], w_ge};
        end
    end

    assign o_status.div_sat = r_sat;
    assign o_quot           = r_sat ? '1 : r_quot;

endmodule
`default_nettype wire

FILE: src/hpcc_datapath.sv
// Datapath: configuration registers, target evaluation and the tick state update.
`timescale 1ns / 1ps
`default_nettype none
module hpcc_datapath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [hpcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [hpcc_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  wire  [hpcc_pkg::KEY_W-1:0]           i_key_code,
    input  wire  [hpcc_pkg::P_W-1:0]             i_pressure_sample,
    input  hpcc_pkg::t_cmd                       i_cmd,
    output hpcc_pkg::t_status                    o_status,
    output logic [hpcc_pkg::OUT_TDATA_W-1:0]     o_tdata
);

    // Configuration.
    logic [hpcc_pkg::MODE_W-1:0] r_mode;
    logic [hpcc_pkg::SPAN_W-1:0] r_spanner;
    logic [hpcc_pkg::TORQ_W-1:0] r_user_torque;
    logic [hpcc_pkg::TORQ_W-1:0] r_bolt_torque;
    logic [hpcc_pkg::TORQ_W-1:0] r_gear_torque;
    logic [hpcc_pkg::ORT_W-1:0]  r_ort;

    // Captured word and evaluation results.
    logic [hpcc_pkg::KEY_W-1:0]  r_key;
    logic [hpcc_pkg::P_W-1:0]    r_p;
    logic                        r_ge;
    logic                        r_win;
    logic [hpcc_pkg::P_W-1:0]    r_cand;

    // Tick state.
    logic                          r_motor, n_motor;
    logic [1:0]                    r_vmode, n_vmode;
    logic                          r_reached, n_reached;
    logic [hpcc_pkg::IDLE_W-1:0]   r_idle, n_idle;
    logic [hpcc_pkg::STATE2_W-1:0] r_run, n_run;
    logic                          r_auto, n_auto;
    logic [hpcc_pkg::P_W-1:0]      r_latched, n_latched;
    logic                          r_valve, n_valve;
    logic                          r_warn, n_warn;
    logic                          r_start, n_start;
    logic [hpcc_pkg::WAIT_W-1:0]   w_wait;

    logic [hpcc_pkg::OUT_TDATA_W-1:0] r_tdata;

    logic [hpcc_pkg::TORQ_W-1:0]   w_torque;
    logic [hpcc_pkg::Q_W-1:0]      w_quot;
    logic [hpcc_pkg::Q_W-1:0]      w_tgt;
    logic                          w_active;
    logic [hpcc_pkg::CMP_W-1:0]    w_p96;
    logic [hpcc_pkg::CMP_W-1:0]    w_t97;
    logic [hpcc_pkg::CMP_W-1:0]    w_t103;
    logic [hpcc_pkg::X_W-1:0]      w_x;
    logic [hpcc_pkg::CAND_W-1:0]   w_cand_prod;
    logic [hpcc_pkg::P_W:0]        w_man_sum;
    logic [hpcc_pkg::IDLE_W-1:0]   w_idle_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= '0;
            r_spanner     <= hpcc_pkg::SPAN_W'(1);
            r_user_torque <= '0;
            r_bolt_torque <= '0;
            r_gear_torque <= '0;
            r_ort         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hpcc_pkg::REG_MODE:    r_mode        <= i_cfg_data[hpcc_pkg::MODE_W-1:0];
                hpcc_pkg::REG_SPANNER: r_spanner     <= i_cfg_data[hpcc_pkg::SPAN_W-1:0];
                hpcc_pkg::REG_USER:    r_user_torque <= i_cfg_data[hpcc_pkg::TORQ_W-1:0];
                hpcc_pkg::REG_BOLT:    r_bolt_torque <= i_cfg_data[hpcc_pkg::TORQ_W-1:0];
                hpcc_pkg::REG_GEAR:    r_gear_torque <= i_cfg_data[hpcc_pkg::TORQ_W-1:0];
                hpcc_pkg::REG_ORT:     r_ort         <= i_cfg_data[hpcc_pkg::ORT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_mode)
            hpcc_pkg::MODE_BOLT: w_torque = r_bolt_torque;
            hpcc_pkg::MODE_GEAR: w_torque = r_gear_torque;
            default:             w_torque = r_user_torque;
        endcase
    end

    hpcc_target u_target (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_torque  (w_torque),
        .i_spanner (r_spanner),
        .o_status  (o_status),
        .o_quot    (w_quot)
    );

    // Final target: cap outside sensor mode or on a zero spanner, bolt offset on the auto key in bolt mode.
    always_comb begin
        if (r_spanner == '0) begin
            w_tgt = hpcc_pkg::CAP_P;
        end else if ((r_mode != hpcc_pkg::MODE_SENSOR) && (w_quot >= hpcc_pkg::CAP_P)) begin
            w_tgt = hpcc_pkg::CAP_P;
        end else begin
            w_tgt = w_quot;
        end
        if ((r_mode == hpcc_pkg::MODE_BOLT) && (r_key == hpcc_pkg::KEY_AUTO) &&
            (w_tgt < hpcc_pkg::BOLT_LIM)) begin
            w_tgt = (w_tgt >= hpcc_pkg::BOLT_OFS) ? (w_tgt - hpcc_pkg::BOLT_OFS) : '0;
        end
    end

    assign w_p96       = (hpcc_pkg::CMP_W'(r_p) << 6) + (hpcc_pkg::CMP_W'(r_p) << 5);
    assign w_t97       = hpcc_pkg::CMP_W'(w_tgt) * hpcc_pkg::CMP_W'(97);
    assign w_t103      = hpcc_pkg::CMP_W'(w_tgt) * hpcc_pkg::CMP_W'(103);
    assign w_x         = (hpcc_pkg::X_W'(r_p) << 4) + (hpcc_pkg::X_W'(r_p) << 3);
    assign w_cand_prod = hpcc_pkg::CAND_W'(w_x) * hpcc_pkg::CAND_W'(hpcc_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key <= i_key_code;
            r_p   <= i_pressure_sample;
        end
        if (i_cmd.eval) begin
            r_ge   <= ({1'b0, r_p} >= w_tgt);
            r_win  <= (w_p96 <= w_t103) && (w_p96 >= w_t97);
            r_cand <= w_cand_prod[hpcc_pkg::RECIP_SH +: hpcc_pkg::P_W];
        end
    end

    assign w_active   = (r_mode == hpcc_pkg::MODE_TORQUE) || (r_mode == hpcc_pkg::MODE_BOLT) ||
                        (r_mode == hpcc_pkg::MODE_GEAR) || (r_mode == hpcc_pkg::MODE_SENSOR);
    assign w_man_sum  = {1'b0, r_p} + {1'b0, ((r_latched < hpcc_pkg::MAN_LIM) ?
                        hpcc_pkg::MAN_OFS_LO : hpcc_pkg::MAN_OFS_HI)};
    assign w_idle_inc = r_idle + 1'b1;

    always_comb begin
        n_motor   = r_motor;
        n_vmode   = r_vmode;
        n_reached = r_reached;
        n_idle    = r_idle;
        n_run     = r_run;
        n_auto    = r_auto;
        n_latched = r_latched;
        n_valve   = r_valve;
        n_warn    = r_warn;
        n_start   = r_start;
        w_wait    = '0;
        if (!w_active) begin
            n_motor = 1'b0;
            n_valve = 1'b0;
            n_warn  = 1'b0;
            n_start = 1'b0;
        end else begin
            unique case (r_key)
                hpcc_pkg::KEY_STOP: begin
                    n_idle  = '0;
                    n_motor = 1'b0;
                    n_valve = 1'b0;
                end
                hpcc_pkg::KEY_AUTO: begin
                    n_idle  = '0;
                    n_vmode = hpcc_pkg::VM_AUTO;
                    n_auto  = 1'b1;
                    n_motor = 1'b1;
                    if (r_ge && !r_reached) begin
                        if (r_win) begin
                            n_latched = r_cand;
                        end
                        n_run     = hpcc_pkg::RUN_STOPPED;
                        n_reached = 1'b1;
                        n_valve   = 1'b0;
                        n_warn    = 1'b0;
                    end else if ((r_p < hpcc_pkg::RET_HI) && (r_p >= hpcc_pkg::RET_LO) &&
                                 r_reached) begin
                        w_wait    = hpcc_pkg::WAIT_W'(r_ort) *
                                    hpcc_pkg::WAIT_W'(hpcc_pkg::WAIT_SCALE);
                        n_run     = hpcc_pkg::RUN_ACTIVE;
                        n_reached = 1'b0;
                        n_valve   = 1'b1;
                        n_warn    = 1'b1;
                    end else if ((r_p < hpcc_pkg::RET_HI) && !r_reached) begin
                        n_run   = hpcc_pkg::RUN_ACTIVE;
                        n_valve = 1'b1;
                        n_warn  = 1'b1;
                    end
                end
                hpcc_pkg::KEY_MANUAL: begin
                    n_idle    = '0;
                    n_auto    = 1'b0;
                    n_motor   = 1'b1;
                    n_run     = hpcc_pkg::RUN_ACTIVE;
                    n_vmode   = hpcc_pkg::VM_MANUAL;
                    n_latched = w_man_sum[hpcc_pkg::P_W] ? hpcc_pkg::P_MAX
                                                         : w_man_sum[hpcc_pkg::P_W-1:0];
                    n_valve   = 1'b1;
                    n_start   = 1'b1;
                end
                default: begin
                    // No key: end the stroke that is under way, then count idle ticks.
                    if (r_vmode == hpcc_pkg::VM_MANUAL) begin
                        n_run   = hpcc_pkg::RUN_STOPPED;
                        n_vmode = hpcc_pkg::VM_NONE;
                        n_valve = 1'b0;
                        n_start = 1'b0;
                    end else if (r_vmode == hpcc_pkg::VM_AUTO) begin
                        n_run     = hpcc_pkg::RUN_ENDED;
                        n_reached = 1'b0;
                        n_vmode   = hpcc_pkg::VM_NONE;
                        n_valve   = 1'b0;
                        n_warn    = 1'b0;
                    end
                    n_idle = w_idle_inc;
                    if (w_idle_inc >= hpcc_pkg::IDLE_LIMIT) begin
                        n_idle = hpcc_pkg::IDLE_HOLD;
                        if (r_motor) begin
                            n_motor = 1'b0;
                            n_valve = 1'b0;
                            n_warn  = 1'b0;
                            n_start = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor   <= 1'b0;
            r_vmode   <= hpcc_pkg::VM_NONE;
            r_reached <= 1'b0;
            r_idle    <= '0;
            r_run     <= hpcc_pkg::RUN_ACTIVE;
            r_auto    <= 1'b0;
            r_latched <= '0;
            r_valve   <= 1'b0;
            r_warn    <= 1'b0;
            r_start   <= 1'b0;
        end else if (i_cmd.commit) begin
            r_motor   <= n_motor;
            r_vmode   <= n_vmode;
            r_reached <= n_reached;
            r_idle    <= n_idle;
            r_run     <= n_run;
            r_auto    <= n_auto;
            r_latched <= n_latched;
            r_valve   <= n_valve;
            r_warn    <= n_warn;
            r_start   <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_tdata <= {4'b0000, w_wait, n_latched, n_reached, n_auto, n_run,
                        n_start, n_warn, n_valve, n_motor};
        end
    end

    assign o_tdata = r_tdata;

endmodule
`default_nettype wire

FILE: src/hpcc_checker.sv
// Port-level checker of the hydraulic pressure cycle controller and its bind.
`timescale 1ns / 1ps
`default_nettype none
module hpcc_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [hpcc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // One tick at a time: the input side closes right after a word is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a tick is in flight");

    // A reported wait comes only with reopened valves and a cleared reached flag.
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[35:20] != 16'd0) |->
            m_axis_tdata[1] && !m_axis_tdata[7])
        else $error("oil return wait without reopening");

    // The valves are never driven with the motor off.
    a_valve_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("valves open with motor off");

    // The cycle state never takes the unused code.
    a_run_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:4] != 2'b11))
        else $error("cycle state out of range");

endmodule

bind hydraulic_pressure_cycle_controller hpcc_checker u_hpcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: dv/hydraulic_pressure_cycle_controller_test.sv
// Self-checking testbench of the hydraulic pressure cycle controller with its own tick predictor.
`timescale 1ns / 1ps
module hydraulic_pressure_cycle_controller_test;
    import hpcc_pkg::*;

    // Mode codes that the package leaves unnamed; all of them switch the tool off.
    localparam logic [MODE_W-1:0] MODE_MENU  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ANGLE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    // Lamp bits of the predicted panel state.
    localparam logic [1:0] LAMP_WARN  = 2'b01;
    localparam logic [1:0] LAMP_START = 2'b10;

    // Covers one tick still in flight through the block, with margin.
    localparam int unsigned SETTLE_CYCLES  = 24;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned RANDOM_PHASES  = 12;
    localparam int unsigned PHASE_ITEMS    = 70;
    localparam int unsigned IDLE_RUN_TICKS = 1510;
    localparam longint unsigned RUN_LIMIT_NS = 1000000;

    // Result word as it sits on m_axis_tdata, most significant field first.
    typedef struct packed {
        logic [3:0]          pad;
        logic [WAIT_W-1:0]   reopen_wait;
        logic [P_W-1:0]      reported_pressure;
        logic                pressure_reached;
        logic                auto_drive;
        logic [STATE2_W-1:0] cycle_state;
        logic                start_led;
        logic                warning_led;
        logic                valves_open;
        logic                motor_on;
    } t_tick_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0: key_code[1:0], pressure_sample[13:2], zero pad [15:14].
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0: motor_on, valves_open, warning_led, start_led, cycle_state[5:4],
    // auto_drive, pressure_reached, reported_pressure[19:8], reopen_wait[35:20], pad.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    hydraulic_pressure_cycle_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Ticks waiting to be offered, and the results predicted for accepted ticks.
    logic [IN_TDATA_W-1:0] pending_ticks[$];
    t_tick_result          predicted_results[$];
    int unsigned           mismatch_count = 0;

    // Idle percentages of the two sides and the long receiver hold-off.
    int unsigned tx_idle_pct = 11;
    int unsigned rx_idle_pct = 75;
    logic        hold_go = 1'b0;
    int unsigned hold_left = 0;

    // Shadow copy of the setup registers, at their reset values.
    logic [MODE_W-1:0] cfg_mode = MODE_MENU;
    logic [SPAN_W-1:0] cfg_span = SPAN_W'(1);
    logic [TORQ_W-1:0] cfg_user = '0;
    logic [TORQ_W-1:0] cfg_bolt = '0;
    logic [TORQ_W-1:0] cfg_gear = '0;
    logic [ORT_W-1:0]  cfg_ort = '0;

    // Predicted controller state, at its reset values.
    logic                st_motor = 1'b0;
    logic [1:0]          st_valve_mode = VM_NONE;
    logic                st_reached = 1'b0;
    logic [IDLE_W-1:0]   st_idle = '0;
    logic [STATE2_W-1:0] st_run = RUN_ACTIVE;
    logic                st_auto = 1'b0;
    logic [P_W-1:0]      st_latched = '0;
    logic                st_valve = 1'b0;
    logic [1:0]          st_lamps = '0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Target pressure in 1/16 units for the current setup. The bolt offset applies
    // only to an auto key, so the caller says whether this is one.
    function automatic logic [63:0] calc_target(input logic auto_key);
        logic [TORQ_W-1:0] torque;
        logic [63:0]       t;
        torque = (cfg_mode == MODE_BOLT) ? cfg_bolt : (cfg_mode == MODE_GEAR) ? cfg_gear : cfg_user;
        if (cfg_span == '0) begin
            // A zero spanner gives the cap in every mode, sensor mode too.
            t = 64'(CAP_P);
        end else begin
            t = (64'(torque) * 64'(TGT_SCALE)) / 64'(cfg_span);
            if (cfg_mode != MODE_SENSOR && t >= 64'(CAP_P)) begin
                t = 64'(CAP_P);
            end
        end
        if (auto_key && cfg_mode == MODE_BOLT && t < 64'(BOLT_LIM)) begin
            t = (t >= 64'(BOLT_OFS)) ? t - 64'(BOLT_OFS) : 64'd0;
        end
        return t;
    endfunction

    // Advance the predicted state by one accepted tick and queue the result it gives.
    task automatic predict_controller_step(input logic [IN_TDATA_W-1:0] word);
        logic [KEY_W-1:0]  key;
        logic [P_W-1:0]    p;
        logic [WAIT_W-1:0] wait_ticks;
        logic [63:0]       tgt;
        logic [63:0]       p96;
        logic [63:0]       man_sum;
        t_tick_result      r;
        key = word[KEY_W-1:0];
        p = word[KEY_W +: P_W];
        wait_ticks = '0;
        if (cfg_mode inside {MODE_TORQUE, MODE_BOLT, MODE_GEAR, MODE_SENSOR}) begin
            case (key)
                KEY_STOP: begin
                    // Stop leaves the lamps as they are.
                    st_idle = '0;
                    st_motor = 1'b0;
                    st_valve = 1'b0;
                end
                KEY_AUTO: begin
                    st_idle = '0;
                    st_valve_mode = VM_AUTO;
                    st_auto = 1'b1;
                    st_motor = 1'b1;
                    tgt = calc_target(1'b1);
                    if (64'(p) >= tgt && !st_reached) begin
                        // Target reached: latch the scaled reading only inside the window.
                        p96 = 64'(p) * 64'd96;
                        if (p96 <= tgt * 64'd103 && p96 >= tgt * 64'd97) begin
                            st_latched = P_W'(p96 / 64'd100);
                        end
                        st_run = RUN_STOPPED;
                        st_reached = 1'b1;
                        st_valve = 1'b0;
                        st_lamps = st_lamps & ~LAMP_WARN;
                    end else if (p < RET_HI && p >= RET_LO && st_reached) begin
                        // Oil has returned: reopen and report the wait.
                        wait_ticks = WAIT_W'(32'(cfg_ort) * WAIT_SCALE);
                        st_run = RUN_ACTIVE;
                        st_reached = 1'b0;
                        st_valve = 1'b1;
                        st_lamps = st_lamps | LAMP_WARN;
                    end else if (p < RET_HI && !st_reached) begin
                        st_run = RUN_ACTIVE;
                        st_valve = 1'b1;
                        st_lamps = st_lamps | LAMP_WARN;
                    end
                end
                KEY_MANUAL: begin
                    st_idle = '0;
                    st_auto = 1'b0;
                    st_motor = 1'b1;
                    st_run = RUN_ACTIVE;
                    st_valve_mode = VM_MANUAL;
                    man_sum = 64'(p) + ((st_latched < MAN_LIM) ? 64'(MAN_OFS_LO) : 64'(MAN_OFS_HI));
                    st_latched = (man_sum > 64'(P_MAX)) ? P_MAX : P_W'(man_sum);
                    st_valve = 1'b1;
                    st_lamps = st_lamps | LAMP_START;
                end
                default: begin
                    // No key ends a manual stroke or an auto cycle, then counts idle time.
                    if (st_valve_mode == VM_MANUAL) begin
                        st_run = RUN_STOPPED;
                        st_valve_mode = VM_NONE;
                        st_valve = 1'b0;
                        st_lamps = st_lamps & ~LAMP_START;
                    end
                    if (st_valve_mode == VM_AUTO) begin
                        st_run = RUN_ENDED;
                        st_reached = 1'b0;
                        st_valve_mode = VM_NONE;
                        st_valve = 1'b0;
                        st_lamps = st_lamps & ~LAMP_WARN;
                    end
                    st_idle = st_idle + 1'b1;
                    if (st_idle >= IDLE_LIMIT) begin
                        st_idle = IDLE_HOLD;
                        if (st_motor) begin
                            st_motor = 1'b0;
                            st_valve = 1'b0;
                            st_lamps = '0;
                        end
                    end
                end
            endcase
        end else begin
            // Menu, angle and the unused codes force everything off.
            st_motor = 1'b0;
            st_valve = 1'b0;
            st_lamps = '0;
        end
        r = '0;
        r.motor_on = st_motor;
        r.valves_open = st_valve;
        r.warning_led = st_lamps[0];
        r.start_led = st_lamps[1];
        r.cycle_state = st_run;
        r.auto_drive = st_auto;
        r.pressure_reached = st_reached;
        r.reported_pressure = st_latched;
        r.reopen_wait = wait_ticks;
        predicted_results.push_back(r);
    endtask

    task automatic compare_result(input t_tick_result got, input t_tick_result want);
        if (got.motor_on !== want.motor_on)
            report_mismatch("motor_on", got.motor_on, want.motor_on);
        if (got.valves_open !== want.valves_open)
            report_mismatch("valves_open", got.valves_open, want.valves_open);
        if (got.warning_led !== want.warning_led)
            report_mismatch("warning_led", got.warning_led, want.warning_led);
        if (got.start_led !== want.start_led)
            report_mismatch("start_led", got.start_led, want.start_led);
        if (got.cycle_state !== want.cycle_state)
            report_mismatch("cycle_state", got.cycle_state, want.cycle_state);
        if (got.auto_drive !== want.auto_drive)
            report_mismatch("auto_drive", got.auto_drive, want.auto_drive);
        if (got.pressure_reached !== want.pressure_reached)
            report_mismatch("pressure_reached", got.pressure_reached, want.pressure_reached);
        if (got.reported_pressure !== want.reported_pressure)
            report_mismatch("reported_pressure", got.reported_pressure, want.reported_pressure);
        if (got.reopen_wait !== want.reopen_wait)
            report_mismatch("reopen_wait", got.reopen_wait, want.reopen_wait);
    endtask

    // Driver: predicts each word at the edge that accepts it, then offers the next
    // pending tick unless this cycle is picked as an idle one. A word that is not
    // yet taken stays on the bus unchanged.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_controller_step(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tdata <= pending_ticks.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps pushing meanwhile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result word with no tick pending", m_axis_tdata, 0);
                end else begin
                    compare_result(t_tick_result'(m_axis_tdata), predicted_results.pop_front());
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void queue_tick(input logic [KEY_W-1:0] key, input int unsigned p);
        pending_ticks.push_back({2'b00, P_W'(p), key});
    endfunction

    // One auto cycle: start below the return limit, climb, hit the target (mostly
    // inside the latch window), stay up, then return, release or stop.
    function automatic int unsigned queue_auto_cycle();
        logic [63:0] t;
        int unsigned tg;
        int unsigned lo;
        int unsigned hi;
        int unsigned count;
        int unsigned pick;
        t = calc_target(1'b1);
        tg = (t > 64'(P_MAX)) ? int'(P_MAX) : int'(t[31:0]);
        count = 0;
        repeat ($urandom_range(2)) begin
            queue_tick(KEY_AUTO, $urandom_range(RET_LO, RET_HI - 1));
            count++;
        end
        if (tg > RET_HI) begin
            repeat ($urandom_range(3)) begin
                queue_tick(KEY_AUTO, $urandom_range(RET_HI, tg - 1));
                count++;
            end
        end
        lo = (97 * tg + 95) / 96;
        hi = (103 * tg) / 96;
        if (hi > int'(P_MAX)) hi = P_MAX;
        if (lo <= hi && $urandom_range(99) < 70) begin
            queue_tick(KEY_AUTO, $urandom_range(lo, hi));
        end else begin
            queue_tick(KEY_AUTO, $urandom_range(tg, P_MAX));
        end
        count++;
        repeat ($urandom_range(2)) begin
            queue_tick(KEY_AUTO, $urandom_range(RET_HI, P_MAX));
            count++;
        end
        pick = $urandom_range(99);
        if (pick < 50) queue_tick(KEY_AUTO, $urandom_range(RET_LO, RET_HI - 1));
        else if (pick < 60) queue_tick(KEY_AUTO, $urandom_range(RET_LO - 1));
        else if (pick < 80) queue_tick(KEY_NONE, $urandom_range(P_MAX));
        else queue_tick(KEY_STOP, $urandom_range(P_MAX));
        return count + 1;
    endfunction

    function automatic int unsigned queue_manual_run();
        int unsigned count;
        count = $urandom_range(1, 4);
        repeat (count) queue_tick(KEY_MANUAL, $urandom_range(P_MAX));
        if ($urandom_range(99) < 80) begin
            queue_tick(KEY_NONE, $urandom_range(P_MAX));
            count++;
        end
        return count;
    endfunction

    // Mostly well-formed auto cycles and manual strokes, with stops and raw noise between.
    task automatic fill_random(input int unsigned n_items);
        int unsigned added;
        int unsigned pick;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                added += queue_auto_cycle();
            end else if (pick < 70) begin
                added += queue_manual_run();
            end else if (pick < 78) begin
                queue_tick(KEY_STOP, $urandom_range(P_MAX));
                added++;
            end else begin
                queue_tick(KEY_W'($urandom_range(3)), $urandom_range(P_MAX));
                added++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DAT_W'(val);
        case (idx)
            REG_MODE:    cfg_mode = MODE_W'(val);
            REG_SPANNER: cfg_span = SPAN_W'(val);
            REG_USER:    cfg_user = TORQ_W'(val);
            REG_BOLT:    cfg_bolt = TORQ_W'(val);
            REG_GEAR:    cfg_gear = TORQ_W'(val);
            REG_ORT:     cfg_ort = ORT_W'(val);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_config(input logic [MODE_W-1:0] mode, input int unsigned span,
                                input int unsigned user, input int unsigned bolt,
                                input int unsigned gear, input int unsigned ort);
        write_reg(REG_MODE, mode);
        write_reg(REG_SPANNER, span);
        write_reg(REG_USER, user);
        write_reg(REG_BOLT, bolt);
        write_reg(REG_GEAR, gear);
        write_reg(REG_ORT, ort);
    endtask

    // Random setup whose target mostly lands inside the pressure range.
    task automatic write_random_config();
        logic [MODE_W-1:0] mode;
        int unsigned       want;
        int unsigned       span;
        int unsigned       torque;
        if ($urandom_range(99) < 75) begin
            case ($urandom_range(3))
                0: mode = MODE_TORQUE;
                1: mode = MODE_BOLT;
                2: mode = MODE_GEAR;
                default: mode = MODE_SENSOR;
            endcase
        end else begin
            mode = MODE_W'($urandom_range(7));
        end
        if ($urandom_range(99) < 25) want = $urandom_range(400);
        else want = $urandom_range((mode == MODE_SENSOR) ? 3800 : 1400);
        span = $urandom_range(1000, 1000000);
        torque = int'((64'(want) * 64'(span)) / 64'(TGT_SCALE));
        if (torque > 100000) torque = 100000;
        write_config(mode, span,
                     (mode == MODE_BOLT || mode == MODE_GEAR) ? $urandom_range(100000) : torque,
                     (mode == MODE_BOLT) ? torque : $urandom_range(100000),
                     (mode == MODE_GEAR) ? torque : $urandom_range(100000),
                     $urandom_range(255));
    endtask

    // Setup writes are safe only once every result is back and the block has settled.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_ticks.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset select menu mode: every key leaves the tool off.
        queue_tick(KEY_AUTO, 0);
        queue_tick(KEY_MANUAL, P_MAX);
        queue_tick(KEY_NONE, 0);
        queue_tick(KEY_STOP, P_MAX);
        wait_drained();

        // Torque mode, target 800, longest oil return wait.
        write_config(MODE_TORQUE, 100000, 500, 0, 0, 255);
        queue_tick(KEY_AUTO, 100);      // below target and the return limit: valves open
        queue_tick(KEY_AUTO, 500);      // climbing, no branch taken
        queue_tick(KEY_AUTO, 822);      // target reached inside the latch window
        queue_tick(KEY_AUTO, P_MAX);    // already reached, nothing changes
        queue_tick(KEY_AUTO, 120);      // oil return reopens and reports the wait
        queue_tick(KEY_AUTO, 2000);     // reached again, but far outside the window
        queue_tick(KEY_NONE, 0);        // releasing the key ends the auto cycle
        queue_tick(KEY_MANUAL, 0);      // latch high: the small manual offset
        queue_tick(KEY_MANUAL, P_MAX);  // latch low: the large offset, and it saturates
        queue_tick(KEY_NONE, 300);      // end of the manual stroke
        queue_tick(KEY_MANUAL, 200);
        queue_tick(KEY_STOP, 0);        // stop keeps the lamps
        queue_tick(KEY_NONE, 0);
        wait_drained();

        // Zero spanner in bolt mode: the cap, with no bolt offset.
        write_config(MODE_BOLT, 0, 0, 777, 0, 0);
        queue_tick(KEY_AUTO, 1119);
        queue_tick(KEY_AUTO, 1200);
        queue_tick(KEY_AUTO, 150);
        wait_drained();

        // Bolt target below the offset: it floors at zero and zero reaches it.
        write_config(MODE_BOLT, 1000000, 0, 100, 0, 3);
        queue_tick(KEY_AUTO, 0);
        queue_tick(KEY_AUTO, RET_LO);
        queue_tick(KEY_STOP, 0);
        wait_drained();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // Sender light and receiver heavy first, then the other way round, then neither.
            if (phase == RANDOM_PHASES / 3) begin
                tx_idle_pct <= 75;
                rx_idle_pct <= 11;
            end else if (phase == 2 * RANDOM_PHASES / 3) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            case (phase)
                0: write_config(MODE_SENSOR, 0, 100000, 0, 100000, 1);
                1: write_config(MODE_SENSOR, 1, 131071, 131071, 131071, 0);
                2: write_config(MODE_GEAR, 1000000, 0, 0, 100000, 128);
                3: write_config(MODE_ANGLE, 160000, 1000, 1000, 1000, 50);
                4: write_config(MODE_SPARE, 160000, 1000, 1000, 1000, 255);
                default: write_random_config();
            endcase
            fill_random(PHASE_ITEMS);
            if (phase == 2 * RANDOM_PHASES / 3) begin
                // The receiver holds off while a full phase of ticks waits to go in.
                @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            wait_drained();
        end

        // A running motor left without keys long enough stops by itself, then the
        // idle count stays pinned.
        write_config(MODE_TORQUE, 160000, 1000, 0, 0, 10);
        queue_tick(KEY_MANUAL, 500);
        repeat (IDLE_RUN_TICKS) queue_tick(KEY_NONE, $urandom_range(P_MAX));
        queue_tick(KEY_MANUAL, 300);
        queue_tick(KEY_NONE, 0);
        queue_tick(KEY_AUTO, 100);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("hydraulic_pressure_cycle_controller verification clean");
        end else begin
            $display("hydraulic_pressure_cycle_controller verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("hydraulic_pressure_cycle_controller verification failed");
        $finish;
    end

endmodule
